FILE: hdl/rviu_pkg.sv
// ----------------------------------------------------------------------------
// RV32I integer unit package
// Operation codes, transaction types and the held result slot type shared
// by the integer unit modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rviu_pkg;

  localparam int unsigned TagBits  = 4;
  localparam int unsigned XLen     = 32;
  localparam int unsigned KindBits = 5;
  localparam int unsigned ShBits   = 5;

  localparam logic [XLen-1:0] LinkStep = XLen'(4);

  typedef enum logic [KindBits-1:0] {
    KIND_ADD   = 5'd0,
    KIND_AND   = 5'd1,
    KIND_AUIPC = 5'd2,
    KIND_BEQ   = 5'd3,
    KIND_BGE   = 5'd4,
    KIND_BGEU  = 5'd5,
    KIND_BLT   = 5'd6,
    KIND_BLTU  = 5'd7,
    KIND_BNE   = 5'd8,
    KIND_JAL   = 5'd9,
    KIND_JALR  = 5'd10,
    KIND_OR    = 5'd11,
    KIND_SLL   = 5'd12,
    KIND_SLTU  = 5'd13,
    KIND_SLT   = 5'd14,
    KIND_SRA   = 5'd15,
    KIND_SRL   = 5'd16,
    KIND_SUB   = 5'd17,
    KIND_XOR   = 5'd18,
    KIND_OTHER = 5'd19
  } kind_e;

  typedef struct packed {
    logic                flush;
    logic                bus_accept;
    logic                issue_valid;
    logic [KindBits-1:0] kind;
    logic [XLen-1:0]     first_operand;
    logic [XLen-1:0]     second_operand;
    logic [XLen-1:0]     offset;
    logic [XLen-1:0]     instr_pc;
    logic [TagBits-1:0]  issue_tag;
  } in_item_t;

  typedef struct packed {
    logic               issue_taken;
    logic               slot_valid;
    logic [TagBits-1:0] slot_tag;
    logic [XLen-1:0]    slot_value;
    logic [XLen-1:0]    slot_next_pc;
    logic               slot_taken;
    logic               slot_control;
  } out_item_t;

  // Contents of the one-entry result slot.
  typedef struct packed {
    logic               valid;
    logic [TagBits-1:0] tag;
    logic [XLen-1:0]    value;
    logic [XLen-1:0]    next_pc;
    logic               taken;
    logic               control;
  } slot_t;

  // Outcome of one operation from the execution logic.
  typedef struct packed {
    logic            ok;
    logic [XLen-1:0] value;
    logic [XLen-1:0] next_pc;
    logic            taken;
    logic            control;
  } alu_res_t;

endpackage

`default_nettype wire

FILE: hdl/rviu_alu.sv
// ----------------------------------------------------------------------------
// RV32I integer execution logic
// Computes the value, next pc and control flags of one integer, branch or
// jump operation; flags kinds that the unit does not execute.
// ----------------------------------------------------------------------------
`default_nettype none

module rviu_alu
  import rviu_pkg::*;
(
  input  logic [KindBits-1:0] kind_i,
  input  logic [XLen-1:0]     a_i,
  input  logic [XLen-1:0]     b_i,
  input  logic [XLen-1:0]     offset_i,
  input  logic [XLen-1:0]     pc_i,
  output alu_res_t            res_o
);

  logic [XLen-1:0]   seq_pc;
  logic [XLen-1:0]   target_pc;
  logic [XLen-1:0]   jalr_sum;
  logic [ShBits-1:0] sh;
  logic              lt_s;
  logic              lt_u;
  logic              is_branch;
  logic              cond;

  assign seq_pc    = pc_i + LinkStep;
  assign target_pc = pc_i + offset_i;
  assign jalr_sum  = a_i + offset_i;
  assign sh        = b_i[ShBits-1:0];
  assign lt_s      = $signed(a_i) < $signed(b_i);
  assign lt_u      = a_i < b_i;

  always_comb begin
    res_o     = '0;
    res_o.ok  = 1'b1;
    res_o.next_pc = seq_pc;
    is_branch = 1'b0;
    cond      = 1'b0;
    case (kind_e'(kind_i))
      KIND_ADD:   res_o.value = a_i + b_i;
      KIND_AND:   res_o.value = a_i & b_i;
      KIND_AUIPC: res_o.value = a_i + b_i;
      KIND_BEQ: begin
        is_branch = 1'b1;
        cond      = a_i == b_i;
      end
      KIND_BGE: begin
        is_branch = 1'b1;
        cond      = !lt_s;
      end
      KIND_BGEU: begin
        is_branch = 1'b1;
        cond      = !lt_u;
      end
      KIND_BLT: begin
        is_branch = 1'b1;
        cond      = lt_s;
      end
      KIND_BLTU: begin
        is_branch = 1'b1;
        cond      = lt_u;
      end
      KIND_BNE: begin
        is_branch = 1'b1;
        cond      = a_i != b_i;
      end
      KIND_JAL: begin
        res_o.value   = seq_pc;
        res_o.next_pc = target_pc;
        res_o.taken   = 1'b1;
        res_o.control = 1'b1;
      end
      KIND_JALR: begin
        res_o.value   = seq_pc;
        res_o.next_pc = {jalr_sum[XLen-1:1], 1'b0};
        res_o.taken   = 1'b1;
        res_o.control = 1'b1;
      end
      KIND_OR:   res_o.value = a_i | b_i;
      KIND_SLL:  res_o.value = a_i << sh;
      KIND_SLTU: res_o.value = {{(XLen-1){1'b0}}, lt_u};
      KIND_SLT:  res_o.value = {{(XLen-1){1'b0}}, lt_s};
      KIND_SRA:  res_o.value = XLen'($signed(a_i) >>> sh);
      KIND_SRL:  res_o.value = a_i >> sh;
      KIND_SUB:  res_o.value = a_i - b_i;
      KIND_XOR:  res_o.value = a_i ^ b_i;
      default:   res_o.ok = 1'b0;
    endcase
    // Branches hold a zero value and resolve to the target or the fall-through.
    if (is_branch) begin
      res_o.control = 1'b1;
      res_o.taken   = cond;
      res_o.next_pc = cond ? target_pc : seq_pc;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rviu_slot.sv
// ----------------------------------------------------------------------------
// RV32I integer unit result slot
// Holds the one pending result, decides whether an offered operation is
// taken and updates the slot once per processed transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rviu_slot
  import rviu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  slot_t    slot_q;
  slot_t    slot_d;
  slot_t    new_slot;
  alu_res_t alu_res;
  logic     take;

  rviu_alu u_alu (
    .kind_i   (item_i.kind),
    .a_i      (item_i.first_operand),
    .b_i      (item_i.second_operand),
    .offset_i (item_i.offset),
    .pc_i     (item_i.instr_pc),
    .res_o    (alu_res)
  );

  // An issue goes in when the slot is empty or drained by the bus this time.
  assign take = !item_i.flush && item_i.issue_valid && alu_res.ok &&
                (!slot_q.valid || item_i.bus_accept);

  always_comb begin
    new_slot.valid   = 1'b1;
    new_slot.tag     = item_i.issue_tag;
    new_slot.value   = alu_res.value;
    new_slot.next_pc = alu_res.next_pc;
    new_slot.taken   = alu_res.taken;
    new_slot.control = alu_res.control;
  end

  always_comb begin
    slot_d = slot_q;
    if (item_i.flush) begin
      slot_d = '0;
    end else if (take) begin
      slot_d = new_slot;
    end else if (item_i.bus_accept && slot_q.valid) begin
      slot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (step_i) begin
      slot_q <= slot_d;
    end
  end

  always_comb begin
    res_o.issue_taken  = take;
    res_o.slot_valid   = slot_q.valid;
    res_o.slot_tag     = slot_q.tag;
    res_o.slot_value   = slot_q.value;
    res_o.slot_next_pc = slot_q.next_pc;
    res_o.slot_taken   = slot_q.taken;
    res_o.slot_control = slot_q.control;
  end

endmodule

`default_nettype wire

FILE: hdl/rv32i_integer_unit_with_result_slot.sv
// ----------------------------------------------------------------------------
// RV32I integer unit with result slot
// Each input transaction carries one snapshot of the unit's control and issue
// signals (flush, bus accept, an offered operation). The unit answers each
// one with exactly one output transaction: whether the operation was taken
// and the result slot as it stood before that transaction was applied.
// Both channels use valid/ready. An accepted input is registered, then
// processed through the execution logic and the slot update into the
// output register, from which it is offered to the receiver. One
// transaction per cycle is sustained while the receiver does not stall;
// the limit is the single slot update per cycle. When the receiver stalls,
// the output register holds and the input register keeps one transaction,
// after which input ready drops; the slot only changes when a transaction
// moves into the output register.
// Reset clears the slot to all zero and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_integer_unit_with_result_slot
  import rviu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t res;
  logic      out_free;
  logic      step;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || step;

  rviu_slot u_slot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A flushed transaction never takes its issue and leaves the slot empty.
  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_q.flush |=> !res.slot_valid)
    else $error("slot not empty after flush");

  a_taken_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.issue_taken |=> res.slot_valid)
    else $error("taken issue did not fill the slot");

  a_taken_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && res.issue_taken |-> !in_q.flush && in_q.issue_valid)
    else $error("issue taken without offer or under flush");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o && !step)
    else $error("input advanced into a stalled output");

endmodule

`default_nettype wire
